FILE: design/palette_color_decompressor_assert.svh
// Assertion macros for the palette colour decompressor.
// Used by the top level; expects aclk and aresetn in scope.
`ifndef PALETTE_COLOR_DECOMPRESSOR_ASSERT_SVH
`define PALETTE_COLOR_DECOMPRESSOR_ASSERT_SVH

// same-cycle implication
`define PCD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("pcd: same-cycle check failed");

// next-cycle implication
`define PCD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("pcd: next-cycle check failed");

`endif

FILE: design/pcd_pkg.sv
// Types and constants shared by the palette colour decompressor.
// No dependencies.
package pcd_pkg;

    typedef enum logic [1:0] {
        FORM_FULL  = 2'b00,
        FORM_RG_EQ = 2'b01,
        FORM_GREY  = 2'b10,
        FORM_RB_EQ = 2'b11
    } form_t;

    typedef enum logic [1:0] {
        PH_FIRST  = 2'b00,
        PH_SECOND = 2'b01,
        PH_THIRD  = 2'b10
    } phase_t;

    typedef enum logic [1:0] {
        REG_START_INDEX = 2'd0,
        REG_COLOR_COUNT = 2'd1,
        REG_GRAY_MODE   = 2'd2
    } reg_addr_t;

    localparam logic [7:0]  START_INDEX_RESET = 8'd0;
    localparam logic [8:0]  COLOR_COUNT_RESET = 9'd64;

    localparam logic [14:0] WEIGHT_RED = 15'd9830;
    localparam logic [14:0] WEIGHT_GRN = 15'd19333;
    localparam logic [14:0] WEIGHT_BLU = 15'd3604;
    localparam logic [22:0] LUMA_ROUND = 23'd16384;

    typedef struct packed {
        logic [7:0] index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last;
    } colour_t;

    typedef struct packed {
        logic       restart;
        logic [7:0] restart_index;
        logic [8:0] color_count;
    } run_ctrl_t;

endpackage

FILE: design/pcd_decode.sv
// Byte parser and index counter: turns stream bytes into registered colours.
// Depends on pcd_pkg.
module pcd_decode
    import pcd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  run_ctrl_t  run_ctrl,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    output logic       col_valid,
    input  logic       col_ready,
    output colour_t    col_data
);

    phase_t     phase_reg, phase_next;
    form_t      form_reg, form_next;
    logic [5:0] red_reg, red_next;
    logic [5:0] green_reg, green_next;
    logic [7:0] index_reg;
    logic [8:0] done_reg;
    logic       col_valid_reg;
    colour_t    col_reg;

    logic       accept;
    logic       emit;
    logic [7:0] emit_red, emit_green, emit_blue;
    logic [8:0] done_inc;
    logic       is_last;

    assign s_ready   = !col_valid_reg || col_ready;
    assign accept    = s_valid && s_ready;
    assign done_inc  = done_reg + 9'd1;
    assign is_last   = (done_inc == run_ctrl.color_count);
    assign col_valid = col_valid_reg;
    assign col_data  = col_reg;

    always_comb begin
        phase_next = phase_reg;
        form_next  = form_reg;
        red_next   = red_reg;
        green_next = green_reg;
        emit       = 1'b0;
        emit_red   = {2'b00, red_reg};
        emit_green = {2'b00, green_reg};
        emit_blue  = s_data_byte;
        if (accept) begin
            case (phase_reg)
                PH_SECOND: begin
                    case (form_reg)
                        FORM_FULL: begin
                            green_next = s_data_byte[5:0];
                            if (s_data_byte[6]) begin
                                emit       = 1'b1;
                                emit_green = {2'b00, s_data_byte[5:0]};
                                emit_blue  = {2'b00, s_data_byte[5:0]};
                            end else begin
                                phase_next = PH_THIRD;
                            end
                        end
                        FORM_RG_EQ: begin
                            emit       = 1'b1;
                            emit_green = {2'b00, red_reg};
                            emit_blue  = s_data_byte;
                        end
                        default: begin
                            emit       = 1'b1;
                            emit_green = s_data_byte;
                            emit_blue  = {2'b00, red_reg};
                        end
                    endcase
                end
                PH_THIRD: begin
                    emit = 1'b1;
                end
                default: begin
                    form_next = form_t'(s_data_byte[7:6]);
                    red_next  = s_data_byte[5:0];
                    if (form_t'(s_data_byte[7:6]) == FORM_GREY) begin
                        emit       = 1'b1;
                        emit_red   = {2'b00, s_data_byte[5:0]};
                        emit_green = {2'b00, s_data_byte[5:0]};
                        emit_blue  = {2'b00, s_data_byte[5:0]};
                    end else begin
                        phase_next = PH_SECOND;
                    end
                end
            endcase
            if (emit) begin
                phase_next = PH_FIRST;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_FIRST;
            form_reg      <= FORM_FULL;
            red_reg       <= '0;
            green_reg     <= '0;
            index_reg     <= START_INDEX_RESET;
            done_reg      <= '0;
            col_valid_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            form_reg  <= form_next;
            red_reg   <= red_next;
            green_reg <= green_next;
            if (run_ctrl.restart || (emit && is_last)) begin
                index_reg <= run_ctrl.restart ? run_ctrl.restart_index
                                              : run_ctrl.restart_index;
                done_reg  <= '0;
            end else if (emit) begin
                index_reg <= index_reg + 8'd1;
                done_reg  <= done_inc;
            end
            if (emit) begin
                col_valid_reg <= 1'b1;
            end else if (col_ready) begin
                col_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            col_reg.index <= index_reg;
            col_reg.red   <= emit_red;
            col_reg.green <= emit_green;
            col_reg.blue  <= emit_blue;
            col_reg.last  <= is_last;
        end
    end

endmodule

FILE: design/pcd_luma.sv
// Output stage: optional grey conversion and the result register.
// Depends on pcd_pkg.
module pcd_luma
    import pcd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       gray_mode,
    input  logic       col_valid,
    output logic       col_ready,
    input  colour_t    col_data,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_dac_index,
    output logic [7:0] m_red_level,
    output logic [7:0] m_green_level,
    output logic [7:0] m_blue_level,
    output logic       m_run_last
);

    logic        m_valid_reg;
    colour_t     out_reg, out_next;
    logic [22:0] luma_sum;
    logic [7:0]  luma;

    assign col_ready = !m_valid_reg || m_ready;

    assign luma_sum = 23'(col_data.red)   * 23'(WEIGHT_RED)
                    + 23'(col_data.green) * 23'(WEIGHT_GRN)
                    + 23'(col_data.blue)  * 23'(WEIGHT_BLU)
                    + LUMA_ROUND;
    assign luma = luma_sum[22:15];

    always_comb begin
        out_next = col_data;
        if (gray_mode) begin
            out_next.red   = luma;
            out_next.green = luma;
            out_next.blue  = luma;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (col_valid && col_ready) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (col_valid && col_ready) begin
            out_reg <= out_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_dac_index   = out_reg.index;
    assign m_red_level   = out_reg.red;
    assign m_green_level = out_reg.green;
    assign m_blue_level  = out_reg.blue;
    assign m_run_last    = out_reg.last;

endmodule

FILE: design/palette_color_decompressor.sv
// Palette colour decompressor: one input byte a cycle unless stalled, one colour per completed entry.
// A colour is registered in the decode stage once its final byte is taken, then in the output stage.
// Throughput: one byte every cycle; backpressure stalls both stages in turn.
// Reset is synchronous, active low: start index 0, count 64, grey off, run restarted.
// Depends on pcd_pkg, pcd_decode, pcd_luma and palette_color_decompressor_assert.svh.
`include "palette_color_decompressor_assert.svh"

module palette_color_decompressor
    import pcd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_addr,
    input  logic [8:0] cfg_wdata,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_dac_index,
    output logic [7:0] m_red_level,
    output logic [7:0] m_green_level,
    output logic [7:0] m_blue_level,
    output logic       m_run_last
);

    logic [7:0] start_index_reg;
    logic [8:0] color_count_reg;
    logic       gray_mode_reg;
    logic       wr_start, wr_count;
    run_ctrl_t  run_ctrl;
    logic       col_valid, col_ready;
    colour_t    col_data;

    assign wr_start = cfg_wr_en && (reg_addr_t'(cfg_addr) == REG_START_INDEX);
    assign wr_count = cfg_wr_en && (reg_addr_t'(cfg_addr) == REG_COLOR_COUNT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_index_reg <= START_INDEX_RESET;
            color_count_reg <= COLOR_COUNT_RESET;
            gray_mode_reg   <= 1'b0;
        end else if (cfg_wr_en) begin
            case (reg_addr_t'(cfg_addr))
                REG_START_INDEX: start_index_reg <= cfg_wdata[7:0];
                REG_COLOR_COUNT: color_count_reg <= cfg_wdata;
                REG_GRAY_MODE:   gray_mode_reg   <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign run_ctrl.restart       = wr_start || wr_count;
    assign run_ctrl.restart_index = wr_start ? cfg_wdata[7:0] : start_index_reg;
    assign run_ctrl.color_count   = color_count_reg;

    pcd_decode u_decode (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .run_ctrl    (run_ctrl),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .col_valid   (col_valid),
        .col_ready   (col_ready),
        .col_data    (col_data)
    );

    pcd_luma u_luma (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .gray_mode     (gray_mode_reg),
        .col_valid     (col_valid),
        .col_ready     (col_ready),
        .col_data      (col_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_dac_index   (m_dac_index),
        .m_red_level   (m_red_level),
        .m_green_level (m_green_level),
        .m_blue_level  (m_blue_level),
        .m_run_last    (m_run_last)
    );

    `PCD_ASSERT_NOW(a_stall_only_when_full, !s_ready, col_valid && m_valid && !m_ready)
    `PCD_ASSERT_NEXT(a_colour_reaches_output, col_valid && col_ready, m_valid)
    `PCD_ASSERT_NEXT(a_plain_red_six_bits, col_valid && col_ready && !gray_mode_reg,
                     m_red_level[7:6] == 2'b00)

endmodule
